FILE: hw/rtl/button_debounce_long_press_macros.svh
// ---------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion shorthands, sampled on i_clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication.
`define BDLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bdlp_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce package
// Types, widths and codes for the debounced long-press button block.
// ---------------------------------------------------------------------------
package bdlp_pkg;

    localparam int TIME_W    = 10;              // time stamp width in ms
    localparam int TICK_LSB  = 4;               // lower time bits ignored
    localparam int MARK_W    = TIME_W - TICK_LSB;
    localparam int EVENT_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] PRESS_DEB_RST   = 10'd48;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST  = 10'd496;
    localparam logic [TIME_W-1:0] REPEAT_RST      = 10'd240;
    localparam logic [TIME_W-1:0] RELEASE_DEB_RST = 10'd48;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DEBOUNCE = 7'b0000010,
        ST_RELEASE  = 7'b0000100,
        ST_PRESSED  = 7'b0001000,
        ST_LONG     = 7'b0010000,
        ST_LONGREL  = 7'b0100000,
        ST_SHORTREL = 7'b1000000
    } t_state;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_SHORT     = 3'd1,
        EV_FIRSTLONG = 3'd2,
        EV_REPEAT    = 3'd3,
        EV_LONGDONE  = 3'd4,
        EV_HELD      = 3'd5
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_DEB   = 2'd0,
        REG_LONG_PRESS  = 2'd1,
        REG_REPEAT      = 2'd2,
        REG_RELEASE_DEB = 2'd3
    } t_reg_idx;

endpackage

FILE: hw/rtl/button_debounce_long_press.sv
// Path: an accepted request passes from the input register to the result register.
// Throughput: one request per cycle unless the result stream stalls; the state
//   machine and one 6-bit time subtract with four 10-bit compares sit in the single
//   stage between the input register and the result register.
// Reset: i_rst_n is synchronous, active low; state returns to idle, the time
//   mark to 0 and the four thresholds to 48/496/240/48 ms.
// ---------------------------------------------------------------------------
// Button debounce with long press and repeat
// Debounces an active-low button from timestamped polls and reports short,
// long, repeated long, long-done and held events, one result per poll.
// ---------------------------------------------------------------------------
`include "button_debounce_long_press_macros.svh"

module button_debounce_long_press (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] pin_level, [10:1] time_now, [15:11] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] event_code, [7:3] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW = bdlp_pkg::TIME_W;
    localparam int MW = bdlp_pkg::MARK_W;
    localparam int LS = bdlp_pkg::TICK_LSB;

    // ---------------- configuration registers ----------------
    logic [TW-1:0] r_press_deb;
    logic [TW-1:0] r_long_press;
    logic [TW-1:0] r_repeat;
    logic [TW-1:0] r_release_deb;
    logic          cfg_wr;
    logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    // registers sit on word addresses; byte offset bits are ignored
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_deb   <= bdlp_pkg::PRESS_DEB_RST;
            r_long_press  <= bdlp_pkg::LONG_PRESS_RST;
            r_repeat      <= bdlp_pkg::REPEAT_RST;
            r_release_deb <= bdlp_pkg::RELEASE_DEB_RST;
        end else if (cfg_wr) begin
            unique case (bdlp_pkg::t_reg_idx'(cfg_idx))
                bdlp_pkg::REG_PRESS_DEB:   r_press_deb   <= pwdata[TW-1:0];
                bdlp_pkg::REG_LONG_PRESS:  r_long_press  <= pwdata[TW-1:0];
                bdlp_pkg::REG_REPEAT:      r_repeat      <= pwdata[TW-1:0];
                bdlp_pkg::REG_RELEASE_DEB: r_release_deb <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (bdlp_pkg::t_reg_idx'(cfg_idx))
            bdlp_pkg::REG_PRESS_DEB:   prdata = {{(32-TW){1'b0}}, r_press_deb};
            bdlp_pkg::REG_LONG_PRESS:  prdata = {{(32-TW){1'b0}}, r_long_press};
            bdlp_pkg::REG_REPEAT:      prdata = {{(32-TW){1'b0}}, r_repeat};
            bdlp_pkg::REG_RELEASE_DEB: prdata = {{(32-TW){1'b0}}, r_release_deb};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic          r_in_valid;
    logic          r_in_pin;
    logic [MW-1:0] r_in_tick;   // time bits 9..4
    logic          r_out_valid;
    logic          adv;         // result register can take the stage output

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload needs no reset; load on every accepted request
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pin  <= s_axis_tdata[0];
            r_in_tick <= s_axis_tdata[TW:1+LS];
        end
    end

    // ---------------- state machine stage ----------------
    bdlp_pkg::t_state r_state, n_state;
    logic [MW-1:0]    r_mark, n_mark;
    bdlp_pkg::t_event n_event;
    logic [MW-1:0]    tick_diff;
    logic [TW-1:0]    elapsed;
    logic             fire;      // stage output moves into the result register

    // elapsed time wraps naturally in the 6-bit tick domain
    assign tick_diff = r_in_tick - r_mark;
    assign elapsed   = {tick_diff, {LS{1'b0}}};
    assign fire      = r_in_valid && adv;

    always_comb begin
        bdlp_pkg::t_event ev;
        ev      = bdlp_pkg::EV_NONE;
        n_state = r_state;
        n_mark  = r_mark;
        unique case (r_state)
            bdlp_pkg::ST_IDLE: begin
                if (!r_in_pin) begin
                    n_state = bdlp_pkg::ST_DEBOUNCE;
                    n_mark  = r_in_tick;
                end
            end
            bdlp_pkg::ST_DEBOUNCE: begin
                if (r_in_pin) begin
                    n_state = bdlp_pkg::ST_IDLE;
                end else if (elapsed >= r_press_deb) begin
                    n_state = bdlp_pkg::ST_PRESSED;
                end
            end
            bdlp_pkg::ST_PRESSED: begin
                if (r_in_pin) begin
                    n_mark  = r_in_tick;
                    n_state = bdlp_pkg::ST_SHORTREL;
                end else if (elapsed >= r_long_press) begin
                    ev      = bdlp_pkg::EV_FIRSTLONG;
                    n_state = bdlp_pkg::ST_LONG;
                    n_mark  = r_in_tick;
                end
            end
            bdlp_pkg::ST_LONG: begin
                if (r_in_pin) begin
                    n_state = bdlp_pkg::ST_LONGREL;
                end else if (elapsed >= r_repeat) begin
                    n_mark = r_in_tick;
                    ev     = bdlp_pkg::EV_REPEAT;
                end
            end
            bdlp_pkg::ST_LONGREL: begin
                if (r_in_pin) begin
                    ev      = bdlp_pkg::EV_LONGDONE;
                    n_state = bdlp_pkg::ST_RELEASE;
                    n_mark  = r_in_tick;
                end else begin
                    n_state = bdlp_pkg::ST_LONG;
                end
            end
            bdlp_pkg::ST_SHORTREL: begin
                if (r_in_pin) begin
                    ev      = bdlp_pkg::EV_SHORT;
                    n_state = bdlp_pkg::ST_RELEASE;
                end else begin
                    n_state = bdlp_pkg::ST_PRESSED;
                end
            end
            bdlp_pkg::ST_RELEASE: begin
                if (r_in_pin) begin
                    if (elapsed >= r_release_deb) begin
                        n_state = bdlp_pkg::ST_IDLE;
                    end
                end else begin
                    // bounce while releasing: restart the release window
                    n_mark = r_in_tick;
                end
            end
            default: ;
        endcase
        // held while the button counts as pressed and nothing else is due
        if (ev == bdlp_pkg::EV_NONE &&
            (n_state == bdlp_pkg::ST_PRESSED || n_state == bdlp_pkg::ST_LONG ||
             n_state == bdlp_pkg::ST_LONGREL || n_state == bdlp_pkg::ST_SHORTREL)) begin
            ev = bdlp_pkg::EV_HELD;
        end
        n_event = ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdlp_pkg::ST_IDLE;
            r_mark  <= '0;
        end else if (fire) begin
            r_state <= n_state;
            r_mark  <= n_mark;
        end
    end

    // ---------------- result register ----------------
    bdlp_pkg::t_event r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_event <= n_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8-bdlp_pkg::EVENT_W){1'b0}}, r_event};

    // ---------------- assertions ----------------
    `BDLP_ASSERT_NEXT(a_stall_holds_state,
        r_out_valid && !m_axis_tready && !$isunknown(r_state),
        $stable(r_state) && $stable(r_mark), "state moved while result stalled")
    `BDLP_ASSERT_NEXT(a_fire_fills_result, fire, r_out_valid,
        "processed request produced no result")
    `BDLP_ASSERT_NEXT(a_short_to_release, fire && n_event == bdlp_pkg::EV_SHORT,
        r_state == bdlp_pkg::ST_RELEASE, "short press not followed by release debounce")
    `BDLP_ASSERT_NOW(a_idle_no_event, fire && r_state == bdlp_pkg::ST_IDLE,
        n_event == bdlp_pkg::EV_NONE, "event reported from idle")

endmodule
